@@ rtl/bdq_pkg.sv @@
package bdq_pkg;

  // Field widths of the request and response channels
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int LEN_W    = 7;

  // Command codes on the request channel
  localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PREPEND    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REM_LAST   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_FIRST  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND_FIRST = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND_LAST  = 3'd5;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Decoded operation handed from the front end to the back end
  typedef enum logic [2:0] {
    OP_APPEND,
    OP_PREPEND,
    OP_REM_LAST,
    OP_REM_FIRST,
    OP_FIND_FIRST,
    OP_FIND_LAST,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
  } work_t;

endpackage

@@ rtl/bdq_if.sv @@
interface bdq_req_if import bdq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [LEN_W-1:0]    length;

  modport source (output valid, output status, output position, output length, input ready);
  modport sink   (input valid, input status, input position, input length, output ready);
endinterface

@@ rtl/bdq_front.sv @@
module bdq_front import bdq_pkg::*; (
  bdq_req_if.sink     req,
  output logic        push_valid,
  input  logic        push_ready,
  output work_t       push_item
);

  // Requests flow straight into the work queue
  assign push_valid = req.valid;
  assign req.ready  = push_ready;

  // Classify the command; unused codes become a no-op
  always_comb begin
    push_item.value = req.value;
    unique case (req.cmd)
      CMD_APPEND:     push_item.op = OP_APPEND;
      CMD_PREPEND:    push_item.op = OP_PREPEND;
      CMD_REM_LAST:   push_item.op = OP_REM_LAST;
      CMD_REM_FIRST:  push_item.op = OP_REM_FIRST;
      CMD_FIND_FIRST: push_item.op = OP_FIND_FIRST;
      CMD_FIND_LAST:  push_item.op = OP_FIND_LAST;
      default:        push_item.op = OP_NOP;
    endcase
  end

endmodule

@@ rtl/bdq_queue.sv @@
module bdq_queue import bdq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_item
);

  localparam int QueueDepth = 2;

  work_t       slots [QueueDepth];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push_fire;
  logic        pop_fire;

  assign push_ready = (fill != 2'(QueueDepth));
  assign pop_valid  = (fill != 2'd0);
  assign pop_item   = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push_fire) wr_ptr <= ~wr_ptr;
      if (pop_fire)  rd_ptr <= ~rd_ptr;
      unique case ({push_fire, pop_fire})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/bdq_back.sv @@
module bdq_back import bdq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  work_t       pop_item,
  bdq_rsp_if.source   rsp
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC  = CW'(DEPTH);
  localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  // Physical slot of a logical position in the ring
  function automatic logic [IW-1:0] phys_idx(input logic [IW-1:0] base,
                                             input logic [CW-1:0] offs);
    logic [CW:0] sum;
    sum = {{(CW + 1 - IW){1'b0}}, base} + {1'b0, offs};
    if (sum >= (CW + 1)'(DEPTH)) sum = sum - (CW + 1)'(DEPTH);
    return sum[IW-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] len_field(input logic [CW-1:0] c);
    logic [CW+LEN_W-1:0] t;
    t = {{LEN_W{1'b0}}, c};
    return t[LEN_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pos_field(input logic [IW-1:0] p);
    logic [IW+POS_W-1:0] t;
    t = {{POS_W{1'b0}}, p};
    return t[POS_W-1:0];
  endfunction

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data;

  state_t             state;
  logic [IW-1:0]      head;
  logic [CW-1:0]      count;
  logic [VALUE_W-1:0] key;
  logic               find_last;
  logic [IW-1:0]      scan_phys;
  logic [IW-1:0]      scan_log;
  logic [CW-1:0]      left;
  logic               cmp_valid;
  logic [IW-1:0]      cmp_log;
  logic               cmp_last;

  logic               pop_fire;
  logic               full;
  logic               empty;
  logic [IW-1:0]      head_inc;
  logic [IW-1:0]      head_dec;
  logic [CW-1:0]      cnt_m1;
  logic [IW-1:0]      head_next;
  logic [CW-1:0]      count_next;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic               res_now;
  status_t            res_status;
  logic               scan_start;
  logic               scan_issue;
  logic               hit;
  logic               scan_done;

  // Take new work only when idle and the response register frees up
  assign pop_ready = (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign pop_fire  = pop_valid && pop_ready;

  assign full     = (count == DepthC);
  assign empty    = (count == '0);
  assign head_inc = (head == LastIdx) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? LastIdx : head - 1'b1;
  assign cnt_m1   = count - 1'b1;

  // Execute inserts, removes and unused codes directly and launch finds
  always_comb begin
    head_next  = head;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = phys_idx(head, count);
    res_now    = 1'b0;
    res_status = ST_DONE;
    scan_start = 1'b0;
    if (pop_fire) begin
      unique case (pop_item.op)
        OP_APPEND: begin
          res_now = 1'b1;
          if (full) begin
            res_status = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            count_next = count + 1'b1;
          end
        end
        OP_PREPEND: begin
          res_now = 1'b1;
          if (full) begin
            res_status = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = head_dec;
            head_next  = head_dec;
            count_next = count + 1'b1;
          end
        end
        OP_REM_LAST: begin
          res_now = 1'b1;
          if (empty) res_status = ST_EMPTY;
          else       count_next = cnt_m1;
        end
        OP_REM_FIRST: begin
          res_now = 1'b1;
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            head_next  = head_inc;
            count_next = cnt_m1;
          end
        end
        OP_FIND_FIRST, OP_FIND_LAST: begin
          if (empty) begin
            res_now    = 1'b1;
            res_status = ST_NOT_FOUND;
          end else begin
            scan_start = 1'b1;
          end
        end
        default: res_now = 1'b1;
      endcase
    end
  end

  // Scan: one read issued per cycle, compare in the cycle after
  assign scan_issue = (state == S_SCAN) && (left != '0);
  assign hit        = cmp_valid && (rd_data == key);
  assign scan_done  = cmp_valid && (hit || cmp_last);

  // Element store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= pop_item.value;
    rd_data <= mem[scan_phys];
  end

  // Control, scan walker and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      scan_phys <= '0;
      left      <= '0;
      cmp_valid <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      head  <= head_next;
      count <= count_next;

      unique case (state)
        S_IDLE: if (scan_start) state <= S_SCAN;
        S_SCAN: if (scan_done)  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase

      if (scan_start) begin
        key       <= pop_item.value;
        find_last <= (pop_item.op == OP_FIND_LAST);
        left      <= count;
        if (pop_item.op == OP_FIND_LAST) begin
          scan_phys <= phys_idx(head, cnt_m1);
          scan_log  <= cnt_m1[IW-1:0];
        end else begin
          scan_phys <= head;
          scan_log  <= '0;
        end
      end else if (scan_issue) begin
        left     <= left - 1'b1;
        cmp_log  <= scan_log;
        cmp_last <= (left == CW'(1));
        if (find_last) begin
          scan_phys <= (scan_phys == '0) ? LastIdx : scan_phys - 1'b1;
          scan_log  <= scan_log - 1'b1;
        end else begin
          scan_phys <= (scan_phys == LastIdx) ? '0 : scan_phys + 1'b1;
          scan_log  <= scan_log + 1'b1;
        end
      end

      cmp_valid <= scan_issue && !scan_done;

      // Load the response register; a taken response frees it
      if (res_now) begin
        rsp.valid    <= 1'b1;
        rsp.status   <= res_status;
        rsp.position <= '0;
        rsp.length   <= len_field(count_next);
      end else if (scan_done) begin
        rsp.valid    <= 1'b1;
        rsp.status   <= hit ? ST_DONE : ST_NOT_FOUND;
        rsp.position <= hit ? pos_field(cmp_log) : '0;
        rsp.length   <= len_field(count);
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid    <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/bounded_deque_with_search.sv @@
// Channel  Dir  Payload                         Handshake
// req      in   cmd[2:0], value[31:0] signed    valid/ready
// rsp      out  status[1:0], position[5:0],     valid/ready
//               length[6:0]
//
// Storage is a ring of DEPTH words with a head pointer, so both ends
// can insert and remove. Find is limited by the single read port of
// the ring, which the scan walks one element per cycle with a
// registered read; a match ends the scan early.
// A 2-entry queue after the command decode keeps taking requests, until
// it fills, while the back end scans or the response register waits.
// Reset is synchronous; the ring contents are not cleared, only head and count.
module bounded_deque_with_search import bdq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  bdq_req_if.sink    req,
  bdq_rsp_if.source  rsp
);

  logic  push_valid;
  logic  push_ready;
  work_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  work_t pop_item;

  // Command decode
  bdq_front u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Work queue between decode and execution
  bdq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Ring storage, search and response
  bdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .rsp       (rsp)
  );

endmodule

@@ rtl/bdq_checker.sv @@
module bdq_checker import bdq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [POS_W-1:0]    rsp_position,
  input logic [LEN_W-1:0]    rsp_length
);

  localparam int DepthMod = DEPTH % (2 ** LEN_W);

  // A stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_position) && $stable(rsp_length))
    else $error("response changed while stalled");

  // A refused insert reports a full store
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_length == LEN_W'(DepthMod))
    else $error("full status with wrong length");

  // An ignored remove reports an empty store
  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_EMPTY |-> rsp_length == '0)
    else $error("empty status with nonzero length");

  // Only a successful find carries a position
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_DONE |-> rsp_position == '0)
    else $error("position set on failed request");

endmodule

bind bounded_deque_with_search bdq_checker #(
  .DEPTH (DEPTH)
) u_bdq_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_position (rsp.position),
  .rsp_length   (rsp.length)
);

@@ sim/tb_top.sv @@
module tb_top;
  import bdq_pkg::*;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT  = 800000;

  // Expected response for one request
  typedef struct {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [LEN_W-1:0]   length;
  } deque_rsp_t;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_t;
  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG} stall_mode_t;

  // Tracks the deque contents and the responses still owed by the block
  class deque_scoreboard;
    logic [VALUE_W-1:0] contents[$];
    deque_rsp_t         awaited[$];
    int unsigned        errors;

    function new();
      errors = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Work out the response to an accepted request and apply it to the contents
    function void note_request(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value);
      deque_rsp_t exp_rsp;
      int         hit;
      exp_rsp.status   = ST_DONE;
      exp_rsp.position = '0;
      hit = -1;
      case (cmd)
        CMD_APPEND, CMD_PREPEND: begin
          if (contents.size() >= DEPTH) begin
            exp_rsp.status = ST_FULL;
          end else if (cmd == CMD_APPEND) begin
            contents.push_back(value);
          end else begin
            contents.push_front(value);
          end
        end
        CMD_REM_LAST, CMD_REM_FIRST: begin
          if (contents.size() == 0) begin
            exp_rsp.status = ST_EMPTY;
          end else if (cmd == CMD_REM_LAST) begin
            void'(contents.pop_back());
          end else begin
            void'(contents.pop_front());
          end
        end
        CMD_FIND_FIRST: begin
          for (int i = 0; i < contents.size() && hit < 0; i++)
            if (contents[i] === value) hit = i;
          if (hit < 0) exp_rsp.status = ST_NOT_FOUND;
          else exp_rsp.position = POS_W'(hit);
        end
        CMD_FIND_LAST: begin
          for (int i = contents.size() - 1; i >= 0 && hit < 0; i--)
            if (contents[i] === value) hit = i;
          if (hit < 0) exp_rsp.status = ST_NOT_FOUND;
          else exp_rsp.position = POS_W'(hit);
        end
        default: ;  // unused codes change nothing
      endcase
      exp_rsp.length = LEN_W'(contents.size());
      awaited.push_back(exp_rsp);
    endfunction

    // Compare one accepted response with the oldest expectation
    function void check_response(logic [STATUS_W-1:0] status, logic [POS_W-1:0] position,
                                 logic [LEN_W-1:0] length);
      deque_rsp_t exp_rsp;
      if (awaited.size() == 0) begin
        $error("unexpected response: status %0d position %0d length %0d",
               status, position, length);
        errors++;
        return;
      end
      exp_rsp = awaited.pop_front();
      if (status !== exp_rsp.status) begin
        $error("status: expected %0d, got %0d", exp_rsp.status, status);
        errors++;
      end
      if (position !== exp_rsp.position) begin
        $error("position: expected %0d, got %0d", exp_rsp.position, position);
        errors++;
      end
      if (length !== exp_rsp.length) begin
        $error("length: expected %0d, got %0d", exp_rsp.length, length);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  bdq_req_if req_ch ();
  bdq_rsp_if rsp_ch ();

  bounded_deque_with_search #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  deque_scoreboard sb = new();

  int          burst_left;
  int unsigned cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bounded_deque_with_search test failed");
      $finish;
    end
  end

  // Response monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(rsp_ch.status, rsp_ch.position, rsp_ch.length);
  end

  // Receiver: stall behavior changes from one stretch to the next
  initial begin
    stall_mode_t mode;
    int          mode_left;
    int          hold_left;
    rsp_ch.ready = 1'b0;
    mode         = STALL_NONE;
    mode_left    = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        STALL_NONE:   rsp_ch.ready <= 1'b1;
        STALL_RANDOM: rsp_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (hold_left == 0) begin
            rsp_ch.ready <= 1'b1;
            hold_left = $urandom_range(1, 16);
          end else begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
          end
        end
      endcase
    end
  end

  // Drive one request; called and returns at a falling edge
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
    int gap;
    req_ch.cmd   <= cmd;
    req_ch.value <= value;
    req_ch.valid <= 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(cmd, value);
    @(negedge clk);
    // end of a burst: idle a while before the next one
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  // Hold off the sender until every owed response has arrived
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // Values mostly from a small pool so finds hit and duplicates are common
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      4, 5, 6: return VALUE_W'($urandom_range(0, 7));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(phase_t phase);
    int roll;
    int ins_w;
    int rem_w;
    roll  = $urandom_range(0, 99);
    ins_w = (phase == PH_GROW) ? 75 : (phase == PH_SHRINK) ? 10 : 35;
    rem_w = (phase == PH_GROW) ? 10 : (phase == PH_SHRINK) ? 75 : 35;
    if (roll < ins_w)               return CMD_APPEND + CMD_W'($urandom_range(0, 1));
    if (roll < ins_w + rem_w)       return CMD_REM_LAST + CMD_W'($urandom_range(0, 1));
    if (roll < 97)                  return CMD_FIND_FIRST + CMD_W'($urandom_range(0, 1));
    return CMD_W'($urandom_range(6, 7));  // unused codes
  endfunction

  initial begin
    phase_t              phase;
    int                  phase_len;
    int                  sent;
    logic [CMD_W-1:0]    cmd;
    logic [VALUE_W-1:0]  value;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd   = '0;
    req_ch.value = '0;
    burst_left   = $urandom_range(1, 30);
    sent         = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty store, unused codes, extremes and duplicates
    send_request(CMD_FIND_FIRST, 32'h0000_0000);
    send_request(CMD_FIND_LAST, 32'hffff_ffff);
    send_request(CMD_REM_LAST, 32'h0);
    send_request(CMD_REM_FIRST, 32'h0);
    send_request(3'd6, 32'hffff_ffff);
    send_request(3'd7, 32'h0);
    send_request(CMD_APPEND, 32'h7fff_ffff);
    send_request(CMD_APPEND, 32'h8000_0000);
    send_request(CMD_PREPEND, 32'h0000_0000);
    send_request(CMD_PREPEND, 32'hffff_ffff);
    send_request(CMD_APPEND, 32'h8000_0000);
    send_request(CMD_FIND_FIRST, 32'h8000_0000);
    send_request(CMD_FIND_LAST, 32'h8000_0000);
    send_request(CMD_FIND_FIRST, 32'hffff_ffff);
    send_request(CMD_FIND_LAST, 32'h7fff_ffff);
    send_request(CMD_FIND_FIRST, 32'h1234_5678);
    send_request(3'd7, 32'h5555_aaaa);
    send_request(CMD_REM_FIRST, 32'h0);
    send_request(CMD_REM_LAST, 32'h0);
    send_request(CMD_FIND_LAST, 32'h0000_0000);
    drain_responses();

    // Random phases biased toward filling, emptying, or neither
    while (sent < RANDOM_ITEMS) begin
      phase     = phase_t'($urandom_range(0, 2));
      phase_len = $urandom_range(40, 120);
      repeat (phase_len) begin
        cmd = pick_cmd(phase);
        if ((cmd == CMD_FIND_FIRST || cmd == CMD_FIND_LAST) && sb.contents.size() != 0 &&
            $urandom_range(0, 1) == 1)
          value = sb.contents[$urandom_range(0, sb.contents.size() - 1)];
        else
          value = pick_value();
        send_request(cmd, value);
        sent++;
      end
      drain_responses();
    end

    // Let any stray response show up
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("bounded_deque_with_search test passed");
    end else begin
      $display("bounded_deque_with_search test failed");
    end
    $finish;
  end

endmodule
